FILE: rtl/core/euq_pkg.sv
// Shared types, constants and fixed-point helpers for the Euler-to-quaternion pipeline.
// Internal arithmetic is Q.20 in 26-bit signed words; no dependencies.
package euq_pkg;

   localparam int FIX_W        = 26;
   localparam int FIX_SHIFT    = 20;
   localparam int NUM_AXES     = 3;
   localparam int CORDIC_STEPS = 20;
   localparam int ROOT_BITS    = 22;
   localparam int TRACE_W      = 23;

   // Axis lanes
   localparam int AXIS_Z = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_X = 2;

   typedef logic signed [FIX_W-1:0] fix_type;
   typedef logic [ROOT_BITS-1:0]    root_type;

   localparam fix_type FIX_ONE     = 26'sd1048576;
   localparam fix_type FIX_PI      = 26'sd3294199;
   localparam fix_type FIX_HALF_PI = 26'sd1647099;
   localparam fix_type CORDIC_GAIN = 26'sd636751;
   localparam fix_type DEGEN_EPS   = 26'sd1024;

   localparam fix_type ATAN_TABLE [CORDIC_STEPS] = '{
      26'sd823550, 26'sd486170, 26'sd256879, 26'sd130396, 26'sd65451,
      26'sd32757,  26'sd16383,  26'sd8192,   26'sd4096,   26'sd2048,
      26'sd1024,   26'sd512,    26'sd256,    26'sd128,    26'sd64,
      26'sd32,     26'sd16,     26'sd8,      26'sd4,      26'sd2
   };

   localparam logic signed [2*FIX_W-1:0] FIX_ROUND = 52'sd524288;

   // Matrix differences and degenerate flag carried beside the root extraction
   typedef struct packed {
      logic    degen;
      fix_type diff_x;
      fix_type diff_y;
      fix_type diff_z;
   } side_type;

   // Q.20 product, rounded with halves toward +infinity
   function automatic fix_type fix_mul(input fix_type a, input fix_type b);
      logic signed [2*FIX_W-1:0] prod;
      prod = a * b;
      prod = prod + FIX_ROUND;
      return fix_type'(prod >>> FIX_SHIFT);
   endfunction

endpackage

FILE: rtl/core/euq_cordic.sv
// Three-lane angle scaling, quadrant fold and 20-step CORDIC sine/cosine pipeline.
// Depends on euq_pkg.
module euq_cordic #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic signed [DATA_WIDTH-1:0] angle   [euq_pkg::NUM_AXES],
   output logic                         out_valid,
   output euq_pkg::fix_type             sin_out [euq_pkg::NUM_AXES],
   output euq_pkg::fix_type             cos_out [euq_pkg::NUM_AXES]
);
   import euq_pkg::*;

   localparam int ANG_FRAC = DATA_WIDTH - 3;
   localparam int UP_SHIFT = (FIX_SHIFT > ANG_FRAC) ? FIX_SHIFT - ANG_FRAC : 0;
   localparam int DN_SHIFT = (ANG_FRAC > FIX_SHIFT) ? ANG_FRAC - FIX_SHIFT : 0;
   localparam int DEPTH    = CORDIC_STEPS + 2;

   fix_type reduced [NUM_AXES];
   logic    flip    [NUM_AXES];

   fix_type x_ff   [NUM_AXES][CORDIC_STEPS+1];
   fix_type y_ff   [NUM_AXES][CORDIC_STEPS+1];
   fix_type a_ff   [NUM_AXES][CORDIC_STEPS+1];
   logic    neg_ff [NUM_AXES][CORDIC_STEPS+1];
   fix_type s_ff   [NUM_AXES];
   fix_type c_ff   [NUM_AXES];
   logic [DEPTH-1:0] valid_ff;

   for (genvar l = 0; l < NUM_AXES; l++) begin : g_lane
      fix_type scaled;

      // Scale the angle to Q.20
      if (DN_SHIFT == 0) begin : g_up
         assign scaled = fix_type'(angle[l]) <<< UP_SHIFT;
      end else begin : g_dn
         logic signed [DATA_WIDTH:0] widened;
         assign widened = (DATA_WIDTH+1)'(angle[l])
                        + ((DATA_WIDTH+1)'(1) <<< (DN_SHIFT - 1));
         assign scaled  = fix_type'(widened >>> DN_SHIFT);
      end

      // Fold into the range -pi/2 .. pi/2
      always_comb begin
         if (scaled > FIX_HALF_PI) begin
            reduced[l] = scaled - FIX_PI;
            flip[l]    = 1'b1;
         end else if (scaled < -FIX_HALF_PI) begin
            reduced[l] = scaled + FIX_PI;
            flip[l]    = 1'b1;
         end else begin
            reduced[l] = scaled;
            flip[l]    = 1'b0;
         end
      end
   end

   // Advance the rotation stages
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int l = 0; l < NUM_AXES; l++) begin
            x_ff[l][0]   <= CORDIC_GAIN;
            y_ff[l][0]   <= '0;
            a_ff[l][0]   <= reduced[l];
            neg_ff[l][0] <= flip[l];
            for (int i = 0; i < CORDIC_STEPS; i++) begin
               if (!a_ff[l][i][FIX_W-1]) begin
                  x_ff[l][i+1] <= x_ff[l][i] - (y_ff[l][i] >>> i);
                  y_ff[l][i+1] <= y_ff[l][i] + (x_ff[l][i] >>> i);
                  a_ff[l][i+1] <= a_ff[l][i] - ATAN_TABLE[i];
               end else begin
                  x_ff[l][i+1] <= x_ff[l][i] + (y_ff[l][i] >>> i);
                  y_ff[l][i+1] <= y_ff[l][i] - (x_ff[l][i] >>> i);
                  a_ff[l][i+1] <= a_ff[l][i] + ATAN_TABLE[i];
               end
               neg_ff[l][i+1] <= neg_ff[l][i];
            end
            // Undo the fold
            c_ff[l] <= neg_ff[l][CORDIC_STEPS] ? -x_ff[l][CORDIC_STEPS] : x_ff[l][CORDIC_STEPS];
            s_ff[l] <= neg_ff[l][CORDIC_STEPS] ? -y_ff[l][CORDIC_STEPS] : y_ff[l][CORDIC_STEPS];
         end
      end
   end

   // Track valid beside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign sin_out   = s_ff;
   assign cos_out   = c_ff;

endmodule

FILE: rtl/core/euq_matrix.sv
// Rotation matrix products and trace/difference sums, three register stages.
// Depends on euq_pkg.
module euq_matrix (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  euq_pkg::fix_type  sin_in [euq_pkg::NUM_AXES],
   input  euq_pkg::fix_type  cos_in [euq_pkg::NUM_AXES],
   output logic              out_valid,
   output euq_pkg::fix_type  trace_out,
   output euq_pkg::side_type side_out
);
   import euq_pkg::*;

   fix_type sz, cz, sy, cy, sx, cx;
   fix_type szsy_ff, czsy_ff, r00_ff, czcx_ff, r22_ff, cysx_ff, czsx_ff;
   fix_type szsx_ff, szcy_ff, szcx_ff, sx_ff, cx_ff, sy_ff;
   fix_type szsysx_ff, szsycx_ff, czsycx_ff, czsysx_ff;
   fix_type r00_2_ff, czcx_2_ff, r22_2_ff, cysx_2_ff, czsx_2_ff;
   fix_type szsx_2_ff, szcy_2_ff, szcx_2_ff, sy_2_ff;
   fix_type trace_ff;
   side_type side_ff;
   fix_type r11, trace;
   logic [2:0] valid_ff;

   assign sz = sin_in[AXIS_Z];
   assign cz = cos_in[AXIS_Z];
   assign sy = sin_in[AXIS_Y];
   assign cy = cos_in[AXIS_Y];
   assign sx = sin_in[AXIS_X];
   assign cx = cos_in[AXIS_X];

   assign r11   = szsysx_ff + czcx_2_ff;
   assign trace = FIX_ONE + r00_2_ff + r11 + r22_2_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         // Two-factor products
         szsy_ff <= fix_mul(sz, sy);
         czsy_ff <= fix_mul(cz, sy);
         r00_ff  <= fix_mul(cz, cy);
         czcx_ff <= fix_mul(cz, cx);
         r22_ff  <= fix_mul(cy, cx);
         cysx_ff <= fix_mul(cy, sx);
         czsx_ff <= fix_mul(cz, sx);
         szsx_ff <= fix_mul(sz, sx);
         szcy_ff <= fix_mul(sz, cy);
         szcx_ff <= fix_mul(sz, cx);
         sx_ff   <= sx;
         cx_ff   <= cx;
         sy_ff   <= sy;
         // Three-factor products
         szsysx_ff <= fix_mul(szsy_ff, sx_ff);
         szsycx_ff <= fix_mul(szsy_ff, cx_ff);
         czsycx_ff <= fix_mul(czsy_ff, cx_ff);
         czsysx_ff <= fix_mul(czsy_ff, sx_ff);
         r00_2_ff  <= r00_ff;
         czcx_2_ff <= czcx_ff;
         r22_2_ff  <= r22_ff;
         cysx_2_ff <= cysx_ff;
         czsx_2_ff <= czsx_ff;
         szsx_2_ff <= szsx_ff;
         szcy_2_ff <= szcy_ff;
         szcx_2_ff <= szcx_ff;
         sy_2_ff   <= sy_ff;
         // Trace and off-diagonal differences
         trace_ff       <= trace;
         side_ff.degen  <= (trace <= DEGEN_EPS);
         side_ff.diff_x <= cysx_2_ff - (szsycx_ff - czsx_2_ff);
         side_ff.diff_y <= czsycx_ff + szsx_2_ff + sy_2_ff;
         side_ff.diff_z <= szcy_2_ff - (czsysx_ff - szcx_2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   assign out_valid = valid_ff[2];
   assign trace_out = trace_ff;
   assign side_out  = side_ff;

endmodule

FILE: rtl/core/euq_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on euq_pkg; carries the side_type payload alongside.
module euq_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_valid,
   input  logic [euq_pkg::TRACE_W-1:0]   radicand,
   input  euq_pkg::side_type             side_in,
   output logic                          out_valid,
   output euq_pkg::root_type             root_out,
   output euq_pkg::side_type             side_out
);
   import euq_pkg::*;

   localparam int RAD_W = 2 * ROOT_BITS;
   localparam int REM_W = ROOT_BITS + 4;
   localparam int DEPTH = ROOT_BITS + 1;

   logic [RAD_W-1:0] bits_ff [ROOT_BITS+1];
   logic [REM_W-1:0] rem_ff  [ROOT_BITS+1];
   root_type         root_ff [ROOT_BITS+1];
   side_type         side_ff [ROOT_BITS+1];
   logic [DEPTH-1:0] valid_ff;

   always_ff @(posedge clock) begin
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      if (enable) begin
         // Load t shifted to Q.40
         bits_ff[0] <= {1'b0, radicand, {FIX_SHIFT{1'b0}}};
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= side_in;
         for (int k = 0; k < ROOT_BITS; k++) begin
            rem_sh = {rem_ff[k][REM_W-3:0], bits_ff[k][RAD_W-1:RAD_W-2]};
            trial  = {2'b00, root_ff[k], 2'b01};
            if (rem_sh >= trial) begin
               rem_ff[k+1]  <= rem_sh - trial;
               root_ff[k+1] <= {root_ff[k][ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_ff[k+1]  <= rem_sh;
               root_ff[k+1] <= {root_ff[k][ROOT_BITS-2:0], 1'b0};
            end
            bits_ff[k+1] <= {bits_ff[k][RAD_W-3:0], 2'b00};
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign root_out  = root_ff[ROOT_BITS];
   assign side_out  = side_ff[ROOT_BITS];

endmodule

FILE: rtl/core/euq_div.sv
// Scalar part and three pipelined restoring dividers for the vector part, with saturation.
// Depends on euq_pkg.
module euq_div #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  euq_pkg::root_type            root_in,
   input  euq_pkg::side_type            side_in,
   output logic                         out_valid,
   output logic signed [DATA_WIDTH-1:0] quat_w,
   output logic signed [DATA_WIDTH-1:0] quat_vec [euq_pkg::NUM_AXES],
   output logic                         degen_out
);
   import euq_pkg::*;

   localparam int QF    = DATA_WIDTH - 2;
   localparam int QB    = DATA_WIDTH;
   localparam int MAG_W = FIX_W - 1;
   localparam int CW    = DATA_WIDTH + FIX_W - 1;
   localparam int DEN_W = ROOT_BITS + 1;
   localparam int W_W   = ROOT_BITS + QF + 1;
   localparam int DEPTH = QB + 2;
   localparam logic [DATA_WIDTH-1:0] POS_LIMIT = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] NEG_LIMIT = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   fix_type                diff   [NUM_AXES];
   logic [MAG_W-1:0]       mag    [NUM_AXES];
   logic [CW-1:0]          num    [NUM_AXES];
   logic [W_W-1:0]         w_sum;
   logic [DATA_WIDTH-1:0]  w_raw;

   logic [CW-1:0]          rem_ff [NUM_AXES][QB+1];
   logic [DATA_WIDTH-1:0]  q_ff   [NUM_AXES][QB+1];
   logic                   neg_ff [NUM_AXES][QB+1];
   logic                   ovf_ff [NUM_AXES][QB+1];
   logic [DEN_W-1:0]       den_ff [QB+1];
   logic [DATA_WIDTH-1:0]  w_ff   [QB+1];
   logic                   dg_ff  [QB+1];
   logic signed [DATA_WIDTH-1:0] qw_ff;
   logic signed [DATA_WIDTH-1:0] qv_ff [NUM_AXES];
   logic                   degen_ff;
   logic [DEPTH-1:0]       valid_ff;

   assign diff[AXIS_Z] = side_in.diff_x;
   assign diff[AXIS_Y] = side_in.diff_y;
   assign diff[AXIS_X] = side_in.diff_z;

   // Numerators: |d| * 2^QF plus half the divisor, for rounding away from zero
   always_comb begin
      for (int l = 0; l < NUM_AXES; l++) begin
         mag[l] = diff[l][FIX_W-1] ? MAG_W'(-diff[l]) : MAG_W'(diff[l]);
         num[l] = (CW'(mag[l]) << QF) + CW'(root_in);
      end
   end

   // Scalar part: s * 2^QF / 2^21, rounded
   assign w_sum = (W_W'(root_in) << QF) + (W_W'(1) << FIX_SHIFT);
   assign w_raw = DATA_WIDTH'(w_sum >> (FIX_SHIFT + 1));

   always_ff @(posedge clock) begin
      logic [CW-1:0]         sub;
      logic [DATA_WIDTH-1:0] q_mag;
      if (enable) begin
         // Prepare divider operands
         den_ff[0] <= {root_in, 1'b0};
         w_ff[0]   <= (w_raw > POS_LIMIT) ? POS_LIMIT : w_raw;
         dg_ff[0]  <= side_in.degen;
         for (int l = 0; l < NUM_AXES; l++) begin
            rem_ff[l][0] <= num[l];
            q_ff[l][0]   <= '0;
            neg_ff[l][0] <= diff[l][FIX_W-1];
            ovf_ff[l][0] <= num[l] >= (CW'({root_in, 1'b0}) << QB);
         end
         // One quotient bit per stage
         for (int j = 0; j < QB; j++) begin
            den_ff[j+1] <= den_ff[j];
            w_ff[j+1]   <= w_ff[j];
            dg_ff[j+1]  <= dg_ff[j];
            for (int l = 0; l < NUM_AXES; l++) begin
               sub = CW'(den_ff[j]) << (QB - 1 - j);
               if (rem_ff[l][j] >= sub) begin
                  rem_ff[l][j+1] <= rem_ff[l][j] - sub;
                  q_ff[l][j+1]   <= {q_ff[l][j][DATA_WIDTH-2:0], 1'b1};
               end else begin
                  rem_ff[l][j+1] <= rem_ff[l][j];
                  q_ff[l][j+1]   <= {q_ff[l][j][DATA_WIDTH-2:0], 1'b0};
               end
               neg_ff[l][j+1] <= neg_ff[l][j];
               ovf_ff[l][j+1] <= ovf_ff[l][j];
            end
         end
         // Apply sign, saturate, zero on degenerate
         degen_ff <= dg_ff[QB];
         qw_ff    <= dg_ff[QB] ? '0 : $signed(w_ff[QB]);
         for (int l = 0; l < NUM_AXES; l++) begin
            q_mag = ovf_ff[l][QB] ? '1 : q_ff[l][QB];
            if (dg_ff[QB]) begin
               qv_ff[l] <= '0;
            end else if (neg_ff[l][QB]) begin
               qv_ff[l] <= (q_mag > NEG_LIMIT) ? $signed(NEG_LIMIT) : $signed(-q_mag);
            end else begin
               qv_ff[l] <= (q_mag > POS_LIMIT) ? $signed(POS_LIMIT) : $signed(q_mag);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign quat_w    = qw_ff;
   assign quat_vec  = qv_ff;
   assign degen_out = degen_ff;

endmodule

FILE: rtl/core/euler_to_quaternion.sv
// ZYX Euler angles to unit quaternion, fully pipelined.
// Throughput one transfer per cycle while the result side does not stall.
// Stages: 22 CORDIC, 3 matrix, 23 square root, DATA_WIDTH + 2 divide and saturate.
// A stall on the result side freezes the whole pipeline; nothing is lost or repeated.
// Synchronous active-high reset clears all valid bits; payload registers are not reset.
// Depends on euq_pkg, euq_cordic, euq_matrix, euq_sqrt and euq_div.
module euler_to_quaternion #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_angle_z,
   input  logic signed [DATA_WIDTH-1:0] req_angle_y,
   input  logic signed [DATA_WIDTH-1:0] req_angle_x,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_w,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_x,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_y,
   output logic signed [DATA_WIDTH-1:0] rsp_quat_z,
   output logic                         rsp_degenerate
);
   import euq_pkg::*;

   logic                         advance;
   logic signed [DATA_WIDTH-1:0] angle [NUM_AXES];
   logic                         cordic_valid, matrix_valid, sqrt_valid;
   fix_type                      sin_v [NUM_AXES];
   fix_type                      cos_v [NUM_AXES];
   fix_type                      trace;
   side_type                     matrix_side, sqrt_side;
   root_type                     root;
   logic signed [DATA_WIDTH-1:0] quat_vec [NUM_AXES];

   // Move every stage unless a finished result is held back
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   assign angle[AXIS_Z] = req_angle_z;
   assign angle[AXIS_Y] = req_angle_y;
   assign angle[AXIS_X] = req_angle_x;

   euq_cordic #(.DATA_WIDTH(DATA_WIDTH)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (req_valid),
      .angle     (angle),
      .out_valid (cordic_valid),
      .sin_out   (sin_v),
      .cos_out   (cos_v)
   );

   euq_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (cordic_valid),
      .sin_in    (sin_v),
      .cos_in    (cos_v),
      .out_valid (matrix_valid),
      .trace_out (trace),
      .side_out  (matrix_side)
   );

   euq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (matrix_valid),
      .radicand  (trace[TRACE_W-1:0]),
      .side_in   (matrix_side),
      .out_valid (sqrt_valid),
      .root_out  (root),
      .side_out  (sqrt_side)
   );

   euq_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (sqrt_valid),
      .root_in   (root),
      .side_in   (sqrt_side),
      .out_valid (rsp_valid),
      .quat_w    (rsp_quat_w),
      .quat_vec  (quat_vec),
      .degen_out (rsp_degenerate)
   );

   assign rsp_quat_x = quat_vec[AXIS_Z];
   assign rsp_quat_y = quat_vec[AXIS_Y];
   assign rsp_quat_z = quat_vec[AXIS_X];

endmodule

FILE: tb/tb_euler_to_quaternion.sv
// Self-checking testbench for euler_to_quaternion: directed rows, then random angle triples.
// Expected quaternions come from a fixed-point predictor in this file; depends on the RTL only.
module tb_euler_to_quaternion;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = 16;
   localparam int ANG_FRAC = DW - 3;
   localparam int QUAT_FRAC = DW - 2;
   localparam int FRAC = 20;
   localparam longint ONE = 64'sd1 << FRAC;
   localparam longint PI_FIX = 3294199;
   localparam longint HALF_PI_FIX = 1647099;
   localparam longint GAIN = 636751;
   localparam longint FLAT_LIMIT = 1024;
   localparam longint WORD_MAX = (64'sd1 << (DW - 1)) - 1;
   localparam longint WORD_MIN = -(64'sd1 << (DW - 1));
   localparam logic signed [DW-1:0] ANG_PI = 16'sd25736;
   localparam logic signed [DW-1:0] ANG_HALF_PI = 16'sd12868;
   localparam int NUM_ROWS = 20;
   localparam int HOLD_CYCLES = 300;
   localparam longint ARCTAN [20] = '{
      823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
      1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
   };

   typedef struct {
      logic signed [DW-1:0] w;
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic signed [DW-1:0] z;
      logic                 flat;
   } quat_rec;

   typedef struct {
      logic signed [DW-1:0] az;
      logic signed [DW-1:0] ay;
      logic signed [DW-1:0] ax;
      logic                 typed;
      quat_rec              want;
   } angle_row;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [DW-1:0] req_angle_z;
   logic signed [DW-1:0] req_angle_y;
   logic signed [DW-1:0] req_angle_x;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [DW-1:0] rsp_quat_w;
   logic signed [DW-1:0] rsp_quat_x;
   logic signed [DW-1:0] rsp_quat_y;
   logic signed [DW-1:0] rsp_quat_z;
   logic                 rsp_degenerate;

   quat_rec   pending_quats[$];
   angle_row  rows[NUM_ROWS];
   int        error_count = 0;
   int        send_idle_pct = 0;
   int        stall_pct = 0;
   bit        hold_request = 0;
   bit        hold_started = 0;
   int        hold_left = 0;

   euler_to_quaternion #(.DATA_WIDTH(DW)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_angle_z(req_angle_z), .req_angle_y(req_angle_y), .req_angle_x(req_angle_x),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x),
      .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z),
      .rsp_degenerate(rsp_degenerate)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Round a right shift, halves toward +infinity
   function automatic longint round_shift(input longint v, input int s);
      if (s == 0) return v;
      return (v + (64'sd1 << (s - 1))) >>> s;
   endfunction

   function automatic longint fix_product(input longint a, input longint b);
      return round_shift(a * b, FRAC);
   endfunction

   function automatic longint clamp_word(input longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   function automatic longint int_sqrt(input longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(root);
   endfunction

   // Nearest-integer quotient, halves away from zero; den is positive
   function automatic longint round_div(input longint num, input longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   // CORDIC sine and cosine of one angle, with folding beyond +-pi/2
   function automatic void angle_sin_cos(input logic signed [DW-1:0] ang,
                                         output longint sn, output longint cs);
      longint a, px, py, nx;
      bit flip;
      a = round_shift(longint'(ang) * ONE, ANG_FRAC);
      flip = 0;
      px = GAIN;
      py = 0;
      if (a > HALF_PI_FIX) begin
         a = a - PI_FIX;
         flip = 1;
      end else if (a < -HALF_PI_FIX) begin
         a = a + PI_FIX;
         flip = 1;
      end
      for (int i = 0; i < 20; i++) begin
         if (a >= 0) begin
            nx = px - (py >>> i);
            py = py + (px >>> i);
            a = a - ARCTAN[i];
         end else begin
            nx = px + (py >>> i);
            py = py - (px >>> i);
            a = a + ARCTAN[i];
         end
         px = nx;
      end
      cs = flip ? -px : px;
      sn = flip ? -py : py;
   endfunction

   // Expected quaternion for one angle triple
   function automatic quat_rec zyx_quaternion(input logic signed [DW-1:0] az,
                                              input logic signed [DW-1:0] ay,
                                              input logic signed [DW-1:0] ax);
      longint sz, cz, sy, cy, sx, cx;
      longint m00, m11, m22, dx, dy, dz, tr, root;
      quat_rec q;
      angle_sin_cos(az, sz, cz);
      angle_sin_cos(ay, sy, cy);
      angle_sin_cos(ax, sx, cx);
      m00 = fix_product(cz, cy);
      m11 = fix_product(fix_product(sz, sy), sx) + fix_product(cz, cx);
      m22 = fix_product(cy, cx);
      dx = fix_product(cy, sx) - (fix_product(fix_product(sz, sy), cx) - fix_product(cz, sx));
      dy = fix_product(fix_product(cz, sy), cx) + fix_product(sz, sx) + sy;
      dz = fix_product(sz, cy) - (fix_product(fix_product(cz, sy), sx) - fix_product(sz, cx));
      tr = ONE + m00 + m11 + m22;
      if (tr <= FLAT_LIMIT) begin
         q = '{w: '0, x: '0, y: '0, z: '0, flat: 1'b1};
         return q;
      end
      root = int_sqrt(longint'(tr) << FRAC);
      q.w = DW'(clamp_word(round_shift(root * (64'sd1 << QUAT_FRAC), FRAC + 1)));
      q.x = DW'(clamp_word(round_div(dx * (64'sd1 << QUAT_FRAC), 2 * root)));
      q.y = DW'(clamp_word(round_div(dy * (64'sd1 << QUAT_FRAC), 2 * root)));
      q.z = DW'(clamp_word(round_div(dz * (64'sd1 << QUAT_FRAC), 2 * root)));
      q.flat = 1'b0;
      return q;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Offer one triple, hold it until the transfer, then queue its expectation
   task automatic send_angles(input logic signed [DW-1:0] az, input logic signed [DW-1:0] ay,
                              input logic signed [DW-1:0] ax, input bit typed,
                              input quat_rec want);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_angle_z <= az;
      req_angle_y <= ay;
      req_angle_x <= ax;
      do @(posedge clock); while (req_stall);
      pending_quats.push_back(typed ? want : zyx_quaternion(az, ay, ax));
   endtask

   function automatic logic signed [DW-1:0] near(input logic signed [DW-1:0] base,
                                                 input int spread);
      return DW'(int'(base) + $urandom_range(2 * spread) - spread);
   endfunction

   // Mostly full-range words; some near a half turn about one axis to reach the flat case
   task automatic random_angles(output logic signed [DW-1:0] az,
                                output logic signed [DW-1:0] ay,
                                output logic signed [DW-1:0] ax);
      logic signed [DW-1:0] t[3];
      int k;
      for (int i = 0; i < 3; i++) t[i] = DW'($urandom);
      k = $urandom_range(9);
      if (k >= 7) begin
         for (int i = 0; i < 3; i++) t[i] = near(16'sd0, 40);
         t[$urandom_range(2)] = near($urandom_range(1) ? ANG_PI : -ANG_PI, 60);
      end else if (k == 6) begin
         t[$urandom_range(2)] = near($urandom_range(1) ? ANG_HALF_PI : -ANG_HALF_PI, 8);
      end
      az = t[0];
      ay = t[1];
      ax = t[2];
   endtask

   // Drive the result-side stall, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request && !hold_started) begin
         hold_started <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Check each result transfer against the oldest expectation
   always @(posedge clock) begin
      quat_rec e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_quats.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
         end else begin
            e = pending_quats.pop_front();
            if (rsp_degenerate !== e.flat)
               report_mismatch($sformatf("degenerate %b, want %b", rsp_degenerate, e.flat));
            if (rsp_quat_w !== e.w)
               report_mismatch($sformatf("quat_w %0d, want %0d", rsp_quat_w, e.w));
            if (rsp_quat_x !== e.x)
               report_mismatch($sformatf("quat_x %0d, want %0d", rsp_quat_x, e.x));
            if (rsp_quat_y !== e.y)
               report_mismatch($sformatf("quat_y %0d, want %0d", rsp_quat_y, e.y));
            if (rsp_quat_z !== e.z)
               report_mismatch($sformatf("quat_z %0d, want %0d", rsp_quat_z, e.z));
         end
      end
   end

   // Limit the run
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      quat_rec zero_flat;
      logic signed [DW-1:0] az, ay, ax;
      zero_flat = '{w: '0, x: '0, y: '0, z: '0, flat: 1'b1};
      // Directed rows: half turns are typed as flat, the rest are predicted
      rows[0]  = '{16'sd0, 16'sd0, 16'sd0, 1'b0, zero_flat};
      rows[1]  = '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, zero_flat};
      rows[2]  = '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, zero_flat};
      rows[3]  = '{16'sd32767, 16'sd0, -16'sd32768, 1'b0, zero_flat};
      rows[4]  = '{-16'sd1, 16'sd1, -16'sd1, 1'b0, zero_flat};
      rows[5]  = '{ANG_PI, 16'sd0, 16'sd0, 1'b1, zero_flat};
      rows[6]  = '{16'sd0, ANG_PI, 16'sd0, 1'b1, zero_flat};
      rows[7]  = '{16'sd0, 16'sd0, ANG_PI, 1'b1, zero_flat};
      rows[8]  = '{-ANG_PI, 16'sd0, 16'sd0, 1'b1, zero_flat};
      rows[9]  = '{16'sd0, 16'sd0, -ANG_PI, 1'b1, zero_flat};
      rows[10] = '{16'sd25600, 16'sd0, 16'sd0, 1'b0, zero_flat};
      rows[11] = '{16'sd0, 16'sd25700, 16'sd30, 1'b0, zero_flat};
      rows[12] = '{16'sd40, -16'sd20, 16'sd25690, 1'b0, zero_flat};
      rows[13] = '{ANG_HALF_PI, ANG_HALF_PI, ANG_HALF_PI, 1'b0, zero_flat};
      rows[14] = '{-ANG_HALF_PI, 16'sd12867, -16'sd12867, 1'b0, zero_flat};
      rows[15] = '{16'sd12867, -ANG_HALF_PI, 16'sd12868, 1'b0, zero_flat};
      rows[16] = '{16'sd8192, 16'sd4096, -16'sd6000, 1'b0, zero_flat};
      rows[17] = '{16'sd21845, -16'sd21846, 16'sd10922, 1'b0, zero_flat};
      rows[18] = '{16'sh5555, -16'sh5556, 16'sh2aaa, 1'b0, zero_flat};
      rows[19] = '{ANG_PI, ANG_PI, ANG_PI, 1'b0, zero_flat};

      reset = 1'b1;
      req_valid = 1'b0;
      req_angle_z = '0;
      req_angle_y = '0;
      req_angle_x = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 11;
      stall_pct = 81;
      foreach (rows[i])
         send_angles(rows[i].az, rows[i].ay, rows[i].ax, rows[i].typed, rows[i].want);

      // Three phases of random triples with varied idling; the last is a long hold-off with a steady sender
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 81 : 0;
         stall_pct = (phase == 0) ? 81 : (phase == 1) ? 11 : 0;
         if (phase == 2) hold_request = 1;
         for (int n = 0; n < 330; n++) begin
            random_angles(az, ay, ax);
            send_angles(az, ay, ax, 1'b0, zero_flat);
         end
      end
      req_valid <= 1'b0;

      // Drain, then allow the pipeline latency to pass
      while (pending_quats.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
